[rtl/ncm_pkg.sv]
// Package for the NCO complex mixer: sample widths, product widths and the
// pipeline control struct shared by the phase, table and mixer modules.
// Depends on nothing.
`timescale 1ns / 1ps

package ncm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int PROD_BITS   = 2 * SAMPLE_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int INC_BITS    = 32;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;

   typedef struct packed {
      logic advance;
      logic accept;
   } ncm_ctl_type;

endpackage

[rtl/nco_complex_mixer_core.sv]
// Channel  Direction  Handshake           Payload
// req      in         req_valid/stall     sample_i, sample_q, block_end_in
// rsp      out        rsp_valid/stall     mixed_i, mixed_q, block_end_out
// csr      in         csr_valid/ready     phase_increment (clears the phase)
//
// One item enters per clock unless a stalled result holds the pipeline.
// The stages are table read, products, then sum, rounding and saturation.
// A stalled result freezes the whole pipeline and stalls the input side.
// Synchronous reset clears the valid bits, the increment and the phase.
// Top level of the NCO complex mixer; depends on ncm_pkg and its submodules.
`timescale 1ns / 1ps

module nco_complex_mixer_core #(
   parameter int PHASE_BITS         = 32,
   parameter int TABLE_ADDRESS_BITS = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  ncm_pkg::sample_type           req_sample_i,
   input  ncm_pkg::sample_type           req_sample_q,
   input  logic                          req_block_end_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ncm_pkg::sample_type           rsp_mixed_i,
   output ncm_pkg::sample_type           rsp_mixed_q,
   output logic                          rsp_block_end_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ncm_pkg::INC_BITS-1:0]  csr_phase_increment
);
   import ncm_pkg::*;

   ncm_ctl_type ctl;
   logic [TABLE_ADDRESS_BITS-1:0] table_addr;
   logic v1_ff;
   logic v2_ff;
   logic v3_ff;
   logic end1_ff;
   logic end2_ff;
   logic end3_ff;
   sample_type samp_i_ff;
   sample_type samp_q_ff;
   sample_type sin_value;
   sample_type cos_value;

   assign ctl.advance = !(v3_ff && rsp_stall);
   assign ctl.accept  = req_valid && ctl.advance;
   assign req_stall   = !ctl.advance;
   assign csr_ready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (ctl.advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         samp_i_ff <= req_sample_i;
         samp_q_ff <= req_sample_q;
         end1_ff <= req_block_end_in;
         end2_ff <= end1_ff;
         end3_ff <= end2_ff;
      end
   end

   ncm_phase_acc #(
      .PHASE_BITS        (PHASE_BITS),
      .TABLE_ADDRESS_BITS(TABLE_ADDRESS_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .inc_write (csr_valid && csr_ready),
      .inc_value (csr_phase_increment),
      .table_addr(table_addr)
   );

   ncm_osc_rom #(
      .TABLE_ADDRESS_BITS(TABLE_ADDRESS_BITS)
   ) u_rom (
      .clock    (clock),
      .ctl      (ctl),
      .addr     (table_addr),
      .sin_value(sin_value),
      .cos_value(cos_value)
   );

   ncm_mixer u_mixer (
      .clock    (clock),
      .ctl      (ctl),
      .sample_i (samp_i_ff),
      .sample_q (samp_q_ff),
      .sin_value(sin_value),
      .cos_value(cos_value),
      .mixed_i  (rsp_mixed_i),
      .mixed_q  (rsp_mixed_q)
   );

   assign rsp_valid = v3_ff;
   assign rsp_block_end_out = end3_ff;

endmodule

[rtl/ncm_phase_acc.sv]
// Phase increment register and phase accumulator of the oscillator.
// Depends on ncm_pkg for the control struct and the increment width.
`timescale 1ns / 1ps

module ncm_phase_acc #(
   parameter int PHASE_BITS         = 32,
   parameter int TABLE_ADDRESS_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ncm_pkg::ncm_ctl_type            ctl,
   input  logic                            inc_write,
   input  logic [ncm_pkg::INC_BITS-1:0]    inc_value,
   output logic [TABLE_ADDRESS_BITS-1:0]   table_addr
);
   import ncm_pkg::*;

   logic [PHASE_BITS-1:0] inc_ff;
   logic [PHASE_BITS-1:0] inc_in;
   logic [PHASE_BITS-1:0] acc_ff;
   logic [PHASE_BITS-1:0] acc_in;

   always_comb begin
      inc_in = inc_ff;
      acc_in = acc_ff;
      if (inc_write) begin
         inc_in = PHASE_BITS'(inc_value);
         acc_in = '0;
      end else if (ctl.accept) begin
         acc_in = acc_ff + inc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff <= '0;
         acc_ff <= '0;
      end else begin
         inc_ff <= inc_in;
         acc_ff <= acc_in;
      end
   end

   assign table_addr = acc_ff[PHASE_BITS-1 -: TABLE_ADDRESS_BITS];

endmodule

[rtl/ncm_osc_rom.sv]
// Sine table with two registered read ports giving sine and cosine.
// The table is built at elaboration; depends on ncm_pkg for the sample width.
`timescale 1ns / 1ps

module ncm_osc_rom #(
   parameter int TABLE_ADDRESS_BITS = 10
) (
   input  logic                           clock,
   input  ncm_pkg::ncm_ctl_type           ctl,
   input  logic [TABLE_ADDRESS_BITS-1:0]  addr,
   output ncm_pkg::sample_type            sin_value,
   output ncm_pkg::sample_type            cos_value
);
   import ncm_pkg::*;

   localparam int ENTRIES = 1 << TABLE_ADDRESS_BITS;
   localparam int QUARTER = ENTRIES / 4;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
   localparam logic [63:0] HALF_Q30 = 64'd1 << 29;
   localparam logic [63:0] AMPLITUDE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input logic [63:0] m);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      x = (HALF_PI_Q30 * m + 64'(QUARTER / 2)) >> (TABLE_ADDRESS_BITS - 2);
      x2 = (x * x + HALF_Q30) >> 30;
      sum = $signed(x);
      term = x;
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd6;
      sum = sum - $signed(term);
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd20;
      sum = sum + $signed(term);
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd42;
      sum = sum - $signed(term);
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd72;
      sum = sum + $signed(term);
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd110;
      sum = sum - $signed(term);
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd156;
      sum = sum + $signed(term);
      term = ((term * x2 + HALF_Q30) >> 30) / 64'd210;
      sum = sum - $signed(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > $signed(ONE_Q30)) begin
         sum = $signed(ONE_Q30);
      end
      return SAMPLE_BITS'(($unsigned(sum) * AMPLITUDE + HALF_Q30) >> 30);
   endfunction

   function automatic logic [ENTRIES*SAMPLE_BITS-1:0] build_table();
      logic [ENTRIES*SAMPLE_BITS-1:0] tbl;
      logic [SAMPLE_BITS-1:0] v;
      int quad;
      int r;
      tbl = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         quad = k >> (TABLE_ADDRESS_BITS - 2);
         r = k & (QUARTER - 1);
         if ((quad & 1) != 0) begin
            v = quarter_sine(64'(QUARTER - r));
         end else begin
            v = quarter_sine(64'(r));
         end
         if ((quad & 2) != 0) begin
            v = -v;
         end
         tbl[k*SAMPLE_BITS +: SAMPLE_BITS] = v;
      end
      return tbl;
   endfunction

   localparam logic [ENTRIES*SAMPLE_BITS-1:0] SINE_TABLE = build_table();

   logic [TABLE_ADDRESS_BITS-1:0] cos_addr;
   sample_type sin_ff;
   sample_type cos_ff;

   assign cos_addr = addr + TABLE_ADDRESS_BITS'(QUARTER);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         sin_ff <= $signed(SINE_TABLE[addr * SAMPLE_BITS +: SAMPLE_BITS]);
         cos_ff <= $signed(SINE_TABLE[cos_addr * SAMPLE_BITS +: SAMPLE_BITS]);
      end
   end

   assign sin_value = sin_ff;
   assign cos_value = cos_ff;

endmodule

[rtl/ncm_mixer.sv]
// Complex multiply of sample and oscillator: registered products, then sum,
// round half up and saturate into the result register. Depends on ncm_pkg.
`timescale 1ns / 1ps

module ncm_mixer (
   input  logic                  clock,
   input  ncm_pkg::ncm_ctl_type  ctl,
   input  ncm_pkg::sample_type   sample_i,
   input  ncm_pkg::sample_type   sample_q,
   input  ncm_pkg::sample_type   sin_value,
   input  ncm_pkg::sample_type   cos_value,
   output ncm_pkg::sample_type   mixed_i,
   output ncm_pkg::sample_type   mixed_q
);
   import ncm_pkg::*;

   localparam int TW = SUM_BITS + 1;
   localparam logic signed [TW-1:0] ROUND_BIAS = TW'(1) << (SAMPLE_BITS - 2);
   localparam logic signed [TW-1:0] MAX_VALUE = (TW'(1) << (SAMPLE_BITS - 1)) - TW'(1);
   localparam logic signed [TW-1:0] MIN_VALUE = -MAX_VALUE - TW'(1);

   function automatic sample_type round_sat(input sum_type acc);
      logic signed [TW-1:0] t;
      logic signed [TW-1:0] q;
      t = TW'(acc) + ROUND_BIAS;
      q = t >>> (SAMPLE_BITS - 1);
      if (q > MAX_VALUE) begin
         q = MAX_VALUE;
      end else if (q < MIN_VALUE) begin
         q = MIN_VALUE;
      end
      return SAMPLE_BITS'(q);
   endfunction

   prod_type ic_ff;
   prod_type qs_ff;
   prod_type is_ff;
   prod_type qc_ff;
   prod_type ic_in;
   prod_type qs_in;
   prod_type is_in;
   prod_type qc_in;
   sum_type sum_i;
   sum_type sum_q;
   sample_type mixed_i_ff;
   sample_type mixed_q_ff;
   sample_type mixed_i_in;
   sample_type mixed_q_in;

   assign ic_in = sample_i * cos_value;
   assign qs_in = sample_q * sin_value;
   assign is_in = sample_i * sin_value;
   assign qc_in = sample_q * cos_value;

   assign sum_i = SUM_BITS'(ic_ff) - SUM_BITS'(qs_ff);
   assign sum_q = SUM_BITS'(is_ff) + SUM_BITS'(qc_ff);
   assign mixed_i_in = round_sat(sum_i);
   assign mixed_q_in = round_sat(sum_q);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         ic_ff <= ic_in;
         qs_ff <= qs_in;
         is_ff <= is_in;
         qc_ff <= qc_in;
         mixed_i_ff <= mixed_i_in;
         mixed_q_ff <= mixed_q_in;
      end
   end

   assign mixed_i = mixed_i_ff;
   assign mixed_q = mixed_q_ff;

endmodule

[rtl/ncm_checker.sv]
// Port-level checks for the NCO complex mixer and the bind that attaches
// them to nco_complex_mixer_core. Depends on ncm_pkg for the sample type.
`timescale 1ns / 1ps

module ncm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input ncm_pkg::sample_type  rsp_mixed_i,
   input ncm_pkg::sample_type  rsp_mixed_q,
   input logic                 rsp_block_end_out
);
   import ncm_pkg::*;

   a_stall_follows_output: assert property (@(posedge clock)
      req_stall == (rsp_valid && rsp_stall))
      else $error("Input stall does not match a stalled result.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !req_stall ##1 !req_stall |=> rsp_valid)
      else $error("Accepted item did not produce a result after three cycles.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result valid right after reset.");

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mixed_i)
         && $stable(rsp_mixed_q) && $stable(rsp_block_end_out))
      else $error("Stalled result changed.");

endmodule

bind nco_complex_mixer_core ncm_checker u_ncm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_mixed_i      (rsp_mixed_i),
   .rsp_mixed_q      (rsp_mixed_q),
   .rsp_block_end_out(rsp_block_end_out)
);
